FILE: rtl/mvsf_pkg.sv
// mvsf_pkg: shared types, codes and helper functions for the memory value scan filter
// no dependencies
package mvsf_pkg;

	localparam int ADDR_BITS  = 26;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 27;
	localparam int CFG_BITS   = 32;
	localparam int IDX_BITS   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS  = 2;

	localparam logic [IDX_BITS-1:0] REG_VALUE_TYPE    = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_PASS_MODE     = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_CONDITION     = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_COMPARE_VALUE = 2'd3;

	localparam logic [1:0] VT_BYTE  = 2'd0;
	localparam logic [1:0] VT_HALF  = 2'd1;
	localparam logic [1:0] VT_WORD  = 2'd2;
	localparam logic [1:0] VT_FLOAT = 2'd3;

	localparam logic [3:0] COND_EQ      = 4'd0;
	localparam logic [3:0] COND_NE      = 4'd1;
	localparam logic [3:0] COND_GT      = 4'd2;
	localparam logic [3:0] COND_LT      = 4'd3;
	localparam logic [3:0] COND_UNKNOWN = 4'd4;
	localparam logic [3:0] COND_SAME    = 4'd5;
	localparam logic [3:0] COND_DIFF    = 4'd6;
	localparam logic [3:0] COND_GREATER = 4'd7;
	localparam logic [3:0] COND_LESS    = 4'd8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// classified request handed from front to back
	typedef struct packed {
		logic                  hit;
		logic                  last;
		logic [ADDR_BITS-1:0]  address;
		logic [VALUE_BITS-1:0] value;
	} mvsf_req_t;

	typedef struct packed {
		logic                  matched;
		logic [ADDR_BITS-1:0]  address;
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] total;
		logic                  pass_end;
	} mvsf_res_t;

	function automatic logic [VALUE_BITS-1:0] width_mask(input logic [1:0] vt);
		logic [VALUE_BITS-1:0] m;
		unique case (vt)
			VT_BYTE: m = 32'h0000_00ff;
			VT_HALF: m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic is_nan(input logic [VALUE_BITS-1:0] v);
		return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
	endfunction

	// order-preserving key for float bits, both zeros equal
	function automatic logic [VALUE_BITS-1:0] float_key(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] k;
		if (v[30:0] == 31'd0) k = 32'h8000_0000;
		else if (v[31]) k = ~v;
		else k = v | 32'h8000_0000;
		return k;
	endfunction

endpackage

FILE: rtl/mvsf_front.sv
// mvsf_front: masks and classifies each incoming word into a hit/miss request
// depends on mvsf_pkg
module mvsf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      value_type,
	input  logic                            pass_mode,
	input  logic [3:0]                      condition,
	input  logic [mvsf_pkg::VALUE_BITS-1:0] compare_value,
	input  logic [mvsf_pkg::ADDR_BITS-1:0]  address,
	input  logic [mvsf_pkg::VALUE_BITS-1:0] current_value,
	input  logic [mvsf_pkg::VALUE_BITS-1:0] previous_value,
	input  logic                            last,
	input  logic                            in_go,
	output logic                            req_valid,
	output mvsf_pkg::mvsf_req_t             req
);

	logic [mvsf_pkg::VALUE_BITS-1:0] m, cur, prev, key, a, b, ka, kb;
	logic nan, use_prev, hit, rel_ok;
	logic [1:0] op;
	logic fp_mode;
	logic req_valid_s1;
	mvsf_pkg::mvsf_req_t req_s1;

	always_comb begin
		m        = mvsf_pkg::width_mask(value_type);
		cur      = current_value & m;
		prev     = previous_value & m;
		key      = compare_value & m;
		fp_mode  = (value_type == mvsf_pkg::VT_FLOAT);
		use_prev = (condition >= mvsf_pkg::COND_SAME);
		a        = cur;
		b        = use_prev ? prev : key;
		op       = use_prev ? 2'(condition - mvsf_pkg::COND_SAME) : condition[1:0];
		nan      = fp_mode && (mvsf_pkg::is_nan(a) || mvsf_pkg::is_nan(b));
		ka       = fp_mode ? mvsf_pkg::float_key(a) : a;
		kb       = fp_mode ? mvsf_pkg::float_key(b) : b;
		unique case (op)
			2'd0:    rel_ok = (ka == kb);
			2'd1:    rel_ok = (ka != kb);
			2'd2:    rel_ok = (ka > kb);
			default: rel_ok = (ka < kb);
		endcase
		if (nan) rel_ok = (op == 2'd1);
		if (condition <= mvsf_pkg::COND_LT) hit = rel_ok;
		else if (condition == mvsf_pkg::COND_UNKNOWN) hit = !pass_mode;
		else if (condition <= mvsf_pkg::COND_LESS) hit = pass_mode && rel_ok;
		else hit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= in_go;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			req_s1.hit     <= hit;
			req_s1.last    <= last;
			req_s1.address <= address;
			req_s1.value   <= cur;
		end
	end

	assign req_valid = req_valid_s1;
	assign req       = req_s1;

endmodule

FILE: rtl/mvsf_back.sv
// mvsf_back: request queue, running match counter and result queue
// depends on mvsf_pkg
module mvsf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  mvsf_pkg::mvsf_req_t  req,
	input  logic                 pop,
	output logic                 space_ok,
	output logic                 empty,
	output mvsf_pkg::mvsf_res_t  res
);

	localparam int D = mvsf_pkg::QUEUE_DEPTH;
	localparam int P = mvsf_pkg::QPTR_BITS;

	// request queue between front and back
	mvsf_pkg::mvsf_req_t rq_q [D];
	logic [P-1:0] rq_wr_q, rq_rd_q;
	logic [P:0]   rq_cnt_q;
	// result queue
	mvsf_pkg::mvsf_res_t oq_q [D];
	logic [P-1:0] oq_wr_q, oq_rd_q;
	logic [P:0]   oq_cnt_q;
	logic [mvsf_pkg::COUNT_BITS-1:0] count_q, count_nx;

	mvsf_pkg::mvsf_req_t head;
	logic rq_nonempty, emits, take, oq_full, oq_pop;
	mvsf_pkg::mvsf_res_t newres;

	always_comb begin
		head        = rq_q[rq_rd_q];
		rq_nonempty = (rq_cnt_q != '0);
		oq_full     = (oq_cnt_q == (P+1)'(D));
		emits       = head.hit || head.last;
		take        = rq_nonempty && (!emits || !oq_full);
		oq_pop      = pop && (oq_cnt_q != '0);
		count_nx    = (head.hit && count_q != mvsf_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
		newres.matched  = head.hit;
		newres.address  = head.address;
		newres.value    = head.value;
		newres.total    = count_nx;
		newres.pass_end = head.last;
	end

	// front has at most two requests in flight beyond the queue
	assign space_ok = (rq_cnt_q <= (P+1)'(D - 2));
	assign empty    = (oq_cnt_q == '0);
	assign res      = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
			count_q  <= '0;
		end else begin
			if (req_valid) rq_wr_q <= rq_wr_q + 1'b1;
			if (take) begin
				rq_rd_q <= rq_rd_q + 1'b1;
				count_q <= head.last ? '0 : count_nx;
			end
			rq_cnt_q <= rq_cnt_q + (P+1)'(req_valid) - (P+1)'(take);
			if (take && emits) oq_wr_q <= oq_wr_q + 1'b1;
			if (oq_pop) oq_rd_q <= oq_rd_q + 1'b1;
			oq_cnt_q <= oq_cnt_q + (P+1)'(take && emits) - (P+1)'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) rq_q[rq_wr_q] <= req;
		if (take && emits) oq_q[oq_wr_q] <= newres;
	end

	a_rq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= (P+1)'(D))
		else $error("request queue overflow");
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= (P+1)'(D))
		else $error("result queue overflow");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && head.last |=> count_q == '0)
		else $error("counter not cleared at pass end");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> rq_cnt_q != (P+1)'(D) || take)
		else $error("request written into full queue");

endmodule

FILE: rtl/memory_value_scan_filter_unit.sv
// memory_value_scan_filter_unit: top level of the memory value scan filter
// depends on mvsf_pkg, mvsf_front, mvsf_back
//
// one word is taken per clock while full is low; a word passes through the
// classifying front register and the request queue and is then retired into
// the result queue. the back retires one request a cycle through the running match
// counter, so sustained rate is one word per cycle as long as results are popped.
// a four-entry request queue decouples the two halves and a four-entry result
// queue sits at the output.
// configuration writes take effect on the next word and are to be made idle.
module memory_value_scan_filter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mvsf_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [mvsf_pkg::CFG_BITS-1:0]   cfg_data,
	// input queue side
	input  logic                            push,
	output logic                            full,
	input  logic [mvsf_pkg::ADDR_BITS-1:0]  address,
	input  logic [mvsf_pkg::VALUE_BITS-1:0] current_value,
	input  logic [mvsf_pkg::VALUE_BITS-1:0] previous_value,
	input  logic                            last,
	// result queue side
	output logic                            empty,
	input  logic                            pop,
	output logic                            matched,
	output logic [mvsf_pkg::ADDR_BITS-1:0]  match_address,
	output logic [mvsf_pkg::VALUE_BITS-1:0] match_value,
	output logic [mvsf_pkg::COUNT_BITS-1:0] match_total,
	output logic                            pass_end
);

	// configuration registers
	logic [1:0]                      value_type_q;
	logic                            pass_mode_q;
	logic [3:0]                      condition_q;
	logic [mvsf_pkg::VALUE_BITS-1:0] compare_value_q;

	logic                 in_go, req_valid, space_ok;
	mvsf_pkg::mvsf_req_t  req;
	mvsf_pkg::mvsf_res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_type_q    <= mvsf_pkg::VT_WORD;
			pass_mode_q     <= 1'b0;
			condition_q     <= mvsf_pkg::COND_EQ;
			compare_value_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvsf_pkg::REG_VALUE_TYPE:    value_type_q    <= cfg_data[1:0];
				mvsf_pkg::REG_PASS_MODE:     pass_mode_q     <= cfg_data[0];
				mvsf_pkg::REG_CONDITION:     condition_q     <= cfg_data[3:0];
				mvsf_pkg::REG_COMPARE_VALUE: compare_value_q <= cfg_data;
			endcase
		end
	end

	// request accepted from the input side
	assign full  = !space_ok;
	assign in_go = push && space_ok;

	mvsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.value_type     (value_type_q),
		.pass_mode      (pass_mode_q),
		.condition      (condition_q),
		.compare_value  (compare_value_q),
		.address        (address),
		.current_value  (current_value),
		.previous_value (previous_value),
		.last           (last),
		.in_go          (in_go),
		.req_valid      (req_valid),
		.req            (req)
	);

	// counter, request queue and result queue
	mvsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.pop       (pop),
		.space_ok  (space_ok),
		.empty     (empty),
		.res       (res)
	);

	assign matched       = res.matched;
	assign match_address = res.address;
	assign match_value   = res.value;
	assign match_total   = res.total;
	assign pass_end      = res.pass_end;

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for memory_value_scan_filter_unit
// depends on mvsf_pkg and the unit under test; directed table then random passes
// results are predicted per accepted request and compared in order at the pop side
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mvsf_pkg::*;

	typedef struct {
		logic [ADDR_BITS-1:0]  address;
		logic [VALUE_BITS-1:0] cur;
		logic [VALUE_BITS-1:0] prev;
		logic                  last;
	} word_t;

	// a directed row: a word, plus an optional hand-typed expectation
	typedef struct {
		logic [1:0]            vt;
		logic                  pm;
		logic [3:0]            cond;
		logic [VALUE_BITS-1:0] key;
		word_t                 w;
		logic                  typed;
		mvsf_res_t             res;
		logic                  has_res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [ADDR_BITS-1:0] address = '0;
	logic [VALUE_BITS-1:0] current_value = '0;
	logic [VALUE_BITS-1:0] previous_value = '0;
	logic last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic matched;
	logic [ADDR_BITS-1:0] match_address;
	logic [VALUE_BITS-1:0] match_value;
	logic [COUNT_BITS-1:0] match_total;
	logic pass_end;

	memory_value_scan_filter_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow configuration and running count
	logic [1:0]            sh_type = VT_WORD;
	logic                  sh_pass = 1'b0;
	logic [3:0]            sh_cond = COND_EQ;
	logic [VALUE_BITS-1:0] sh_key = '0;
	logic [COUNT_BITS-1:0] hit_count = '0;

	mvsf_res_t pending_results[$];
	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int sink_idle_pct = 34;
	bit sink_hold = 1'b0;

	function automatic logic [VALUE_BITS-1:0] lane_mask(logic [1:0] vt);
		case (vt)
			VT_BYTE: return 32'hff;
			VT_HALF: return 32'hffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic nan_bits(logic [VALUE_BITS-1:0] v);
		return v[30:23] == 8'hff && v[22:0] != 0;
	endfunction

	// map float bits onto an unsigned order, both zeros alike
	function automatic logic [VALUE_BITS-1:0] ordered(logic [VALUE_BITS-1:0] v);
		if (v[30:0] == 0) return 32'h8000_0000;
		if (v[31]) return ~v;
		return v | 32'h8000_0000;
	endfunction

	function automatic logic compare_rel(logic [1:0] op, logic [VALUE_BITS-1:0] a,
			logic [VALUE_BITS-1:0] b);
		if (sh_type == VT_FLOAT) begin
			if (nan_bits(a) || nan_bits(b)) return op == 2'd1;
			a = ordered(a);
			b = ordered(b);
		end
		case (op)
			2'd0: return a == b;
			2'd1: return a != b;
			2'd2: return a > b;
			default: return a < b;
		endcase
	endfunction

	// work out the result of one word, updating the running count
	function automatic logic filter_word(word_t w, output mvsf_res_t r);
		logic [VALUE_BITS-1:0] m, cur, prv;
		logic hit;
		m = lane_mask(sh_type);
		cur = w.cur & m;
		prv = w.prev & m;
		hit = 1'b0;
		if (sh_cond <= COND_LT) hit = compare_rel(sh_cond[1:0], cur, sh_key & m);
		else if (sh_cond == COND_UNKNOWN) hit = !sh_pass;
		else if (sh_cond <= COND_LESS)
			hit = sh_pass && compare_rel(2'(sh_cond - COND_SAME), cur, prv);
		if (hit && hit_count != COUNT_MAX) hit_count++;
		r = '{matched: hit, address: w.address, value: cur, total: hit_count,
			pass_end: w.last};
		if (w.last) hit_count = '0;
		return hit || w.last;
	endfunction

	// one register write; the caller drops the write enable afterwards
	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_VALUE_TYPE: sh_type = d[1:0];
			REG_PASS_MODE: sh_pass = d[0];
			REG_CONDITION: sh_cond = d[3:0];
			default: sh_key = d;
		endcase
	endtask

	// let the block drain before touching registers; words without a result may linger
	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] vt, logic pm, logic [3:0] c, logic [31:0] k);
		drain();
		write_reg(REG_VALUE_TYPE, 32'(vt));
		write_reg(REG_PASS_MODE, 32'(pm));
		write_reg(REG_CONDITION, 32'(c));
		write_reg(REG_COMPARE_VALUE, k);
		cfg_we <= 1'b0;
	endtask

	// offer one word until accepted; idles at random beforehand when asked
	task automatic send_word(word_t w, int gap_pct);
		mvsf_res_t r;
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		address <= w.address;
		current_value <= w.cur;
		previous_value <= w.prev;
		last <= w.last;
		@(posedge clk);
		while (full) @(posedge clk);
		words_sent++;
		if (filter_word(w, r)) pending_results.push_back(r);
	endtask

	function automatic logic [31:0] rand_float();
		case ($urandom_range(5))
			0: return {1'($urandom_range(1)), 31'd0};
			1: return {1'($urandom_range(1)), 8'hff, 23'($urandom_range(1, 32'h7fffff))};
			2: return {1'($urandom_range(1)), 8'hff, 23'd0};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_value(logic [1:0] vt, logic [31:0] near);
		logic [31:0] v;
		v = (vt == VT_FLOAT) ? rand_float() : $urandom;
		// keep equal and nearby values frequent so every relation fires
		case ($urandom_range(3))
			0: v = near;
			1: v = (vt == VT_FLOAT) ? v : (near ^ (v & 32'hffff_ff00)) + $urandom_range(2) - 1;
			default: ;
		endcase
		return v;
	endfunction

	// pop side: stalls at random, or holds off entirely while sink_hold is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: addr %h", match_address);
					errors++;
				end else begin
					mvsf_res_t e;
					e = pending_results.pop_front();
					results_seen++;
					if (matched) hits_seen++;
					if (matched !== e.matched) begin
						$error("matched exp %0h got %0h", e.matched, matched);
						errors++;
					end
					if (match_address !== e.address) begin
						$error("match_address exp %h got %h", e.address, match_address);
						errors++;
					end
					if (match_value !== e.value) begin
						$error("match_value exp %h got %h", e.value, match_value);
						errors++;
					end
					if (match_total !== e.total) begin
						$error("match_total exp %0d got %0d", e.total, match_total);
						errors++;
					end
					if (pass_end !== e.pass_end) begin
						$error("pass_end exp %0h got %0h", e.pass_end, pass_end);
						errors++;
					end
				end
			end
			// no idling on this side either during the busy stretch of the run
			pop <= !sink_hold && ($urandom_range(99) >=
				((words_sent > 500 && words_sent < 650) ? 0 : sink_idle_pct));
		end
	end

	// long receiver hold-off, counted here, while the sender keeps offering
	initial begin
		@(posedge clk);
		wait (words_sent >= 300);
		sink_hold = 1'b1;
		repeat (60) @(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end

	row_t rows[$];

	function automatic row_t mk(logic [1:0] vt, logic pm, logic [3:0] c, logic [31:0] k,
			logic [25:0] a, logic [31:0] cur, logic [31:0] prv, logic l);
		row_t r;
		r.vt = vt; r.pm = pm; r.cond = c; r.key = k;
		r.w = '{address: a, cur: cur, prev: prv, last: l};
		r.typed = 1'b0; r.has_res = 1'b0; r.res = '0;
		return r;
	endfunction

	initial begin
		row_t r;
		word_t w;
		mvsf_res_t got;
		logic [1:0] vt;
		logic pm;
		logic [3:0] c;
		logic [31:0] k;
		int n;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: word, first pass, eq against zero
		r = mk(VT_WORD, 0, COND_EQ, 0, 26'h3ff_ffff, 32'h0, 32'hffff_ffff, 0);
		r.typed = 1; r.has_res = 1;
		r.res = '{matched: 1, address: 26'h3ff_ffff, value: 0, total: 1, pass_end: 0};
		rows.push_back(r);
		// no match, not last: nothing
		r = mk(VT_WORD, 0, COND_EQ, 0, 26'h0, 32'hffff_ffff, 0, 0);
		r.typed = 1; rows.push_back(r);
		// no match on last: pass end with count so far
		r = mk(VT_WORD, 0, COND_EQ, 0, 26'h15, 32'h1, 0, 1);
		r.typed = 1; r.has_res = 1;
		r.res = '{matched: 0, address: 26'h15, value: 1, total: 1, pass_end: 1};
		rows.push_back(r);
		rows.push_back(mk(VT_BYTE, 0, COND_EQ, 32'hffff_ff7f, 1, 32'h1234_567f, 0, 0));
		rows.push_back(mk(VT_HALF, 0, COND_NE, 32'hffff, 2, 32'hffff_ffff, 0, 0));
		rows.push_back(mk(VT_WORD, 0, COND_GT, 32'h7fff_ffff, 3, 32'hffff_ffff, 0, 0));
		rows.push_back(mk(VT_WORD, 0, COND_LT, 32'h1, 4, 32'h0, 0, 1));
		rows.push_back(mk(VT_WORD, 0, COND_UNKNOWN, 0, 5, 32'haaaa_5555, 0, 0));
		// unknown in a refining pass never matches
		rows.push_back(mk(VT_WORD, 1, COND_UNKNOWN, 0, 6, 32'h5555_aaaa, 0, 1));
		// previous-value conditions in a first pass never match
		rows.push_back(mk(VT_WORD, 0, COND_SAME, 0, 7, 32'h9, 32'h9, 1));
		// previous value masked to the width
		rows.push_back(mk(VT_BYTE, 1, COND_SAME, 0, 8, 32'h11, 32'hff11, 0));
		rows.push_back(mk(VT_HALF, 1, COND_DIFF, 0, 9, 32'h1_0001, 32'h0001, 0));
		rows.push_back(mk(VT_WORD, 1, COND_GREATER, 0, 10, 32'h8000_0000, 32'h7fff_ffff, 0));
		rows.push_back(mk(VT_WORD, 1, COND_LESS, 0, 11, 32'h0, 32'h1, 1));
		// condition codes above the last never match
		rows.push_back(mk(VT_WORD, 1, 4'hf, 0, 12, 32'h0, 32'h0, 1));
		// float: zeros equal, NaN unordered, negative orders below positive
		rows.push_back(mk(VT_FLOAT, 0, COND_EQ, 32'h8000_0000, 13, 32'h0, 0, 0));
		rows.push_back(mk(VT_FLOAT, 0, COND_EQ, 32'h7fc0_0000, 14, 32'h7fc0_0000, 0, 0));
		rows.push_back(mk(VT_FLOAT, 0, COND_NE, 32'h7fc0_0000, 15, 32'h7fc0_0000, 0, 0));
		rows.push_back(mk(VT_FLOAT, 0, COND_GT, 32'hbf80_0000, 16, 32'h3f80_0000, 0, 0));
		rows.push_back(mk(VT_FLOAT, 0, COND_LT, 32'h7f80_0000, 17, 32'hff80_0000, 0, 1));
		rows.push_back(mk(VT_FLOAT, 1, COND_GREATER, 0, 18, 32'hffff_ffff, 32'h0, 0));
		rows.push_back(mk(VT_FLOAT, 1, COND_SAME, 0, 19, 32'h8000_0000, 32'h0, 1));

		foreach (rows[i]) begin
			r = rows[i];
			if (r.vt != sh_type || r.pm != sh_pass || r.cond != sh_cond || r.key != sh_key)
				set_mode(r.vt, r.pm, r.cond, r.key);
			n = pending_results.size();
			send_word(r.w, 0);
			// hand-typed rows must agree with the predictor's own verdict
			if (r.typed) begin
				if ((pending_results.size() > n) != r.has_res) begin
					$error("row %0d result presence exp %0d", i, r.has_res);
					errors++;
				end else if (r.has_res && pending_results[$] != r.res) begin
					$error("row %0d prediction differs from table", i);
					errors++;
				end
			end
		end

		// random passes with random settings; extremes of the key show up often
		while (words_sent < 950) begin
			vt = 2'($urandom_range(3));
			pm = 1'($urandom_range(1));
			c = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
			case ($urandom_range(3))
				0: k = 32'h0;
				1: k = 32'hffff_ffff;
				default: k = (vt == VT_FLOAT) ? rand_float() : $urandom;
			endcase
			set_mode(vt, pm, c, k);
			n = $urandom_range(10, 80);
			for (int j = 0; j < n; j++) begin
				w.address = 26'($urandom);
				w.cur = rand_value(vt, k);
				w.prev = ($urandom_range(2) == 0) ? w.cur : rand_value(vt, k);
				w.last = (j == n - 1);
				// a stretch with no idling in the middle of the run
				send_word(w, (words_sent > 500 && words_sent < 650) ? 0 : 34);
			end
		end

		// sender pause until everything is back
		drain();

		// long-pass counting: an unknown pass of small values in which every word matches
		set_mode(VT_BYTE, 0, COND_UNKNOWN, 0);
		for (int j = 0; j < 40; j++) begin
			w = '{address: 26'($urandom), cur: $urandom, prev: $urandom, last: j == 39};
			send_word(w, 0);
		end

		drain();
		$display("tb: %0d words sent, %0d results checked (%0d matches), %0d errors",
			words_sent, results_seen, hits_seen, errors);
		$display("tb: all value types, conditions and both pass modes exercised");
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
